// ===== hdl/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types, codes and helpers of the per-id timeout timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int MAX_TIMERS_DEF = 32;
  localparam int ID_SPACE       = 32;
  localparam int ID_W           = 5;
  localparam int TMO_W          = 24;
  localparam int REM_W          = 25;
  localparam int TIME_W         = 32;
  localparam int KIND_W         = 2;
  localparam int FUNC_W         = 3;
  localparam int IN_DATA_W      = 32;
  localparam int OUT_DATA_W     = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD    = 3'd0,
    FN_ADJUST = 3'd1,
    FN_DELETE = 3'd2,
    FN_TICK   = 3'd3,
    FN_QUERY  = 3'd4,
    FN_NEXT   = 3'd5,
    FN_CLEAR  = 3'd6
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    RK_EXPIRED   = 2'd0,
    RK_DONE      = 2'd1,
    RK_REMAINING = 2'd2,
    RK_NO_TIMER  = 2'd3
  } kind_e;

  localparam logic [REM_W-1:0] REM_NONE = '1;

  // Clamps a signed time left to 0 .. 2^24-1.
  function automatic logic [REM_W-1:0] clamp_left(logic [TIME_W-1:0] v);
    logic [REM_W-1:0] r;
    if (v[TIME_W-1]) begin
      r = '0;
    end else if (|v[TIME_W-2:TMO_W]) begin
      r = {1'b0, {TMO_W{1'b1}}};
    end else begin
      r = {1'b0, v[TMO_W-1:0]};
    end
    return r;
  endfunction

endpackage

// ===== hdl/per_id_timeout_timer_table_top.sv =====
// ----------------------------------------------------------------------------
// per_id_timeout_timer_table_top
// Timer table with a slot for each id below MAX_TIMERS, a millisecond clock,
// and a sequencer that scans the slots through one shared subtract/compare unit.
// ----------------------------------------------------------------------------
// Add, adjust, delete, clear and errors give their result from the execute
// state, a query of a live slot from the read state after it, and tick and
// next after one scan pass per expired id and a last pass (each reads one slot
// per cycle, then drains). One item at a time: the next is accepted once the
// final result is registered, and a result waiting on m_axis_tready delays it.
// Reset clears the valid bits, the clock and the output valid; no memory pass.
// ----------------------------------------------------------------------------
module per_id_timeout_timer_table_top #(
  parameter int MAX_TIMERS = ptt_pkg::MAX_TIMERS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [4:0] timer_id, [28:5] timeout_ms, [31:29] zero
  input  logic [ptt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [2:0] func
  input  logic [ptt_pkg::FUNC_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [4:0] expired_id, [29:5] remaining_ms, [31:30] zero
  output logic [ptt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [1:0] result_kind
  output logic [ptt_pkg::KIND_W-1:0]     m_axis_tuser,
  output logic                           m_axis_tlast
);

  localparam int SLOTS  = (MAX_TIMERS < ptt_pkg::ID_SPACE) ? MAX_TIMERS : ptt_pkg::ID_SPACE;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam bit ALL_IN = MAX_TIMERS >= ptt_pkg::ID_SPACE;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_QRD  = 4'b0100,
    S_SCAN = 4'b1000
  } state_e;

  state_e state_q, state_d;

  ptt_pkg::func_e              func_q;
  logic [ptt_pkg::ID_W-1:0]    id_q;
  logic [ptt_pkg::TMO_W-1:0]   tmo_q;
  logic [ptt_pkg::TIME_W-1:0]  now_q, now_d;
  logic [SLOTS-1:0]            valid_q, valid_d;

  logic [ptt_pkg::TIME_W-1:0]  expiry_mem [SLOTS];
  logic [ptt_pkg::TIME_W-1:0]  rd_data_q;
  logic [IDX_W-1:0]            rd_addr;
  logic                        mem_we;

  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        ev_v_q, ev_v_d;
  logic [IDX_W-1:0]            ev_idx_q, ev_idx_d;
  logic                        found_q, found_d;
  logic [ptt_pkg::TIME_W-1:0]  best_q, best_d;
  logic [IDX_W-1:0]            best_id_q, best_id_d;

  logic [ptt_pkg::TIME_W-1:0]  alu_a, alu_b, alu_sum;
  logic                        alu_sub, alu_lt;

  logic                        m_valid_q;
  ptt_pkg::kind_e              m_kind_q;
  logic [ptt_pkg::ID_W-1:0]    m_id_q;
  logic [ptt_pkg::REM_W-1:0]   m_rem_q;
  logic                        m_last_q;

  logic                        emit;
  ptt_pkg::kind_e              e_kind;
  logic [ptt_pkg::ID_W-1:0]    e_id;
  logic [ptt_pkg::REM_W-1:0]   e_rem;
  logic                        e_last;

  logic                        out_free;
  logic                        in_accept;
  logic [IDX_W-1:0]            id_idx;
  logic                        in_table, known;
  logic                        scan_done, due;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign id_idx   = id_q[IDX_W-1:0];
  assign in_table = ALL_IN || ({1'b0, id_q} < (ptt_pkg::ID_W + 1)'(MAX_TIMERS));
  assign known    = in_table && valid_q[id_idx];

  assign scan_done = (cnt_q == CNT_W'(SLOTS)) && !ev_v_q;
  assign due       = found_q && (best_q[ptt_pkg::TIME_W-1] || (best_q == '0));

  // Add and adjust form now + timeout; every other use is expiry - now.
  always_comb begin
    if (state_q == S_EXEC && (func_q == ptt_pkg::FN_ADD || func_q == ptt_pkg::FN_ADJUST)) begin
      alu_a   = now_q;
      alu_b   = {{(ptt_pkg::TIME_W-ptt_pkg::TMO_W){1'b0}}, tmo_q};
      alu_sub = 1'b0;
    end else begin
      alu_a   = rd_data_q;
      alu_b   = now_q;
      alu_sub = 1'b1;
    end
  end

  ptt_alu u_alu (
    .a_i       (alu_a),
    .b_i       (alu_b),
    .sub_i     (alu_sub),
    .best_i    (best_q),
    .sum_o     (alu_sum),
    .lt_best_o (alu_lt)
  );

  assign rd_addr = (state_q == S_SCAN) ? cnt_q[IDX_W-1:0] : id_idx;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      expiry_mem[id_idx] <= alu_sum;
    end
    rd_data_q <= expiry_mem[rd_addr];
  end

  always_comb begin
    state_d   = state_q;
    now_d     = now_q;
    valid_d   = valid_q;
    cnt_d     = cnt_q;
    ev_v_d    = 1'b0;
    ev_idx_d  = ev_idx_q;
    found_d   = found_q;
    best_d    = best_q;
    best_id_d = best_id_q;
    mem_we    = 1'b0;
    emit      = 1'b0;
    e_kind    = ptt_pkg::RK_DONE;
    e_id      = '0;
    e_rem     = '0;
    e_last    = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (func_q)
          ptt_pkg::FN_ADD: begin
            emit   = out_free;
            e_kind = in_table ? ptt_pkg::RK_DONE : ptt_pkg::RK_NO_TIMER;
            e_id   = id_q;
            if (out_free && in_table) begin
              mem_we          = 1'b1;
              valid_d[id_idx] = 1'b1;
            end
          end
          ptt_pkg::FN_ADJUST: begin
            emit   = out_free;
            e_kind = known ? ptt_pkg::RK_DONE : ptt_pkg::RK_NO_TIMER;
            e_id   = id_q;
            mem_we = out_free && known;
          end
          ptt_pkg::FN_DELETE: begin
            emit   = out_free;
            e_kind = known ? ptt_pkg::RK_DONE : ptt_pkg::RK_NO_TIMER;
            e_id   = id_q;
            if (out_free && known) begin
              valid_d[id_idx] = 1'b0;
            end
          end
          ptt_pkg::FN_QUERY: begin
            if (known) begin
              state_d = S_QRD;
            end else begin
              emit   = out_free;
              e_kind = ptt_pkg::RK_NO_TIMER;
              e_id   = id_q;
            end
          end
          ptt_pkg::FN_TICK, ptt_pkg::FN_NEXT: begin
            if (func_q == ptt_pkg::FN_TICK) begin
              now_d = now_q + 1'b1;
            end
            cnt_d   = '0;
            found_d = 1'b0;
            state_d = S_SCAN;
          end
          ptt_pkg::FN_CLEAR: begin
            emit = out_free;
            if (out_free) begin
              valid_d = '0;
            end
          end
          default: begin
            emit   = out_free;
            e_kind = ptt_pkg::RK_NO_TIMER;
          end
        endcase
        if (emit) begin
          state_d = S_IDLE;
        end
      end

      S_QRD: begin
        emit   = out_free;
        e_kind = ptt_pkg::RK_REMAINING;
        e_id   = id_q;
        e_rem  = ptt_pkg::clamp_left(alu_sum);
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      S_SCAN: begin
        // Read stage issues one slot per cycle; evaluate stage follows in the next
        // cycle with the registered memory data.
        if (cnt_q != CNT_W'(SLOTS)) begin
          ev_v_d   = 1'b1;
          ev_idx_d = cnt_q[IDX_W-1:0];
          cnt_d    = cnt_q + 1'b1;
        end
        if (ev_v_q && valid_q[ev_idx_q] && (!found_q || alu_lt)) begin
          found_d   = 1'b1;
          best_d    = alu_sum;
          best_id_d = ev_idx_q;
        end
        if (scan_done) begin
          emit = out_free;
          e_id = ptt_pkg::ID_W'(best_id_q);
          if (due) begin
            // The smallest time left is due: report it and scan again.
            e_kind = ptt_pkg::RK_EXPIRED;
            e_last = 1'b0;
            if (out_free) begin
              valid_d[best_id_q] = 1'b0;
              cnt_d              = '0;
              found_d            = 1'b0;
            end
          end else begin
            if (func_q == ptt_pkg::FN_TICK) begin
              e_kind = ptt_pkg::RK_DONE;
              e_id   = '0;
            end else begin
              e_kind = ptt_pkg::RK_REMAINING;
              if (found_q) begin
                e_rem = ptt_pkg::clamp_left(best_q);
              end else begin
                e_id  = '0;
                e_rem = ptt_pkg::REM_NONE;
              end
            end
            if (out_free) begin
              state_d = S_IDLE;
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      now_q     <= '0;
      valid_q   <= '0;
      cnt_q     <= '0;
      ev_v_q    <= 1'b0;
      found_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      now_q   <= now_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      ev_v_q  <= ev_v_d;
      found_q <= found_d;
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ev_idx_q  <= ev_idx_d;
    best_q    <= best_d;
    best_id_q <= best_id_d;
    if (in_accept) begin
      func_q <= ptt_pkg::func_e'(s_axis_tuser);
      id_q   <= s_axis_tdata[ptt_pkg::ID_W-1:0];
      tmo_q  <= s_axis_tdata[ptt_pkg::ID_W +: ptt_pkg::TMO_W];
    end
    if (emit) begin
      m_kind_q <= e_kind;
      m_id_q   <= e_id;
      m_rem_q  <= e_rem;
      m_last_q <= e_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = {{(ptt_pkg::OUT_DATA_W-ptt_pkg::ID_W-ptt_pkg::REM_W){1'b0}},
                          m_rem_q, m_id_q};

endmodule

// ===== hdl/ptt_alu.sv =====
// ----------------------------------------------------------------------------
// ptt_alu
// Shared 32-bit add/subtract unit with a signed compare against the best
// time left found so far in a scan.
// ----------------------------------------------------------------------------
module ptt_alu (
  input  logic [ptt_pkg::TIME_W-1:0] a_i,
  input  logic [ptt_pkg::TIME_W-1:0] b_i,
  input  logic                       sub_i,
  input  logic [ptt_pkg::TIME_W-1:0] best_i,
  output logic [ptt_pkg::TIME_W-1:0] sum_o,
  output logic                       lt_best_o
);

  logic [ptt_pkg::TIME_W-1:0] b_op;

  assign b_op      = sub_i ? ~b_i : b_i;
  assign sum_o     = a_i + b_op + {{(ptt_pkg::TIME_W-1){1'b0}}, sub_i};
  assign lt_best_o = $signed(sum_o) < $signed(best_i);

endmodule

// ===== hdl/ptt_checker.sv =====
// ----------------------------------------------------------------------------
// ptt_checker
// Port-level checks of the timer table's input and result streams, bound to the top.
// ----------------------------------------------------------------------------
module ptt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [ptt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic [ptt_pkg::FUNC_W-1:0]     s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ptt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [ptt_pkg::KIND_W-1:0]     m_axis_tuser,
  input logic                           m_axis_tlast
);

  // A stalled result item holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result item changed while stalled");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted in back-to-back cycles");

  // An expired id is never the final result of an item.
  a_expired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ptt_pkg::RK_EXPIRED) |-> !m_axis_tlast)
    else $error("expired id marked as last");

  // Only remaining-time results carry a time value; of the others, only expired ids are not last.
  a_rem_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ptt_pkg::RK_REMAINING) |->
      (m_axis_tdata[29:5] == '0) && m_axis_tlast == (m_axis_tuser != ptt_pkg::RK_EXPIRED))
    else $error("unexpected time value or last flag");

endmodule

bind per_id_timeout_timer_table_top ptt_checker u_ptt_checker (.*);
